### hdl/fsbe_pkg.sv
// ----------------------------------------------------------------------------
// fsbe_pkg
// Shared types, codes and constants of the float stack bytecode executor.
// ----------------------------------------------------------------------------
package fsbe_pkg;

  localparam int StackDepth = 256;
  localparam int PoolDepth  = 256;

  localparam logic [31:0] CanonNan = 32'h7FC0_0000;
  localparam logic [31:0] SignBit  = 32'h8000_0000;

  typedef enum logic [2:0] {
    MODE_POOL_WR = 3'd0,
    MODE_RET     = 3'd1,
    MODE_PUSH    = 3'd2,
    MODE_NEG     = 3'd3,
    MODE_ADD     = 3'd4,
    MODE_MUL     = 3'd5,
    MODE_DIV     = 3'd6,
    MODE_SUB     = 3'd7
  } mode_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_RET   = 2'd1,
    STAT_UNDER = 2'd2,
    STAT_OVER  = 2'd3
  } status_e;

  // low two bits of the arithmetic modes
  typedef enum logic [1:0] {
    FP_ADD = 2'd0,
    FP_MUL = 2'd1,
    FP_DIV = 2'd2,
    FP_SUB = 2'd3
  } fp_op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_PUSH,
    S_FP_START,
    S_FP_WAIT,
    S_DONE
  } ctrl_state_e;

  typedef enum logic [2:0] {
    F_IDLE,
    F_ADD,
    F_MUL,
    F_PRE,
    F_DIV,
    F_NORM,
    F_ROUND
  } fpu_state_e;

  typedef struct packed {
    logic    latch;
    logic    pool_wr;
    logic    pool_rd;
    logic    stk_rd;
    logic    push;
    logic    neg;
    logic    fp_start;
    logic    fp_wb;
    logic    out_load;
    logic    status_we;
    status_e status;
  } ctrl_cmd_t;

  typedef struct packed {
    mode_e mode;
    logic  empty;
    logic  lt2;
    logic  full;
    logic  fp_done;
    logic  out_free;
  } dp_stat_t;

endpackage

### hdl/fsbe_fpu.sv
// ----------------------------------------------------------------------------
// fsbe_fpu
// Multi-cycle single-precision add, subtract, multiply and divide with
// round to nearest even and canonical quiet NaN.
// ----------------------------------------------------------------------------
module fsbe_fpu import fsbe_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  fp_op_e      op_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic        done_o,
  output logic [31:0] res_o
);

  fpu_state_e         state_q, state_d;
  logic               done_q, done_d;
  logic [31:0]        res_q, res_d;
  logic               sa_q, sa_d, sb_q, sb_d, s_q, s_d;
  logic signed [11:0] ea_q, ea_d, eb_q, eb_d, e_q, e_d;
  logic [23:0]        da_q, da_d, db_q, db_d;
  logic [49:0]        m_q, m_d;
  logic               st_q, st_d;
  logic [25:0]        r_q, r_d;
  logic [26:0]        qt_q, qt_d;
  logic [4:0]         cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    sa_q  <= sa_d;
    sb_q  <= sb_d;
    s_q   <= s_d;
    ea_q  <= ea_d;
    eb_q  <= eb_d;
    e_q   <= e_d;
    da_q  <= da_d;
    db_q  <= db_d;
    m_q   <= m_d;
    st_q  <= st_d;
    r_q   <= r_d;
    qt_q  <= qt_d;
    cnt_q <= cnt_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  always_comb begin
    logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, bs, sx;
    logic [49:0] mbig, msml, mshift, mmask, msum;
    logic        a_big, sticky;
    logic signed [11:0] diff, ebig;
    logic [47:0] prod;
    logic [25:0] rsub;
    logic        ge;
    logic [26:0] qn;
    logic [23:0] mant, mant_r;
    logic [24:0] sum25;
    logic        g, stk, inc;
    logic signed [11:0] e_r;

    state_d = state_q;
    done_d  = 1'b0;
    res_d   = res_q;
    sa_d = sa_q; sb_d = sb_q; s_d = s_q;
    ea_d = ea_q; eb_d = eb_q; e_d = e_q;
    da_d = da_q; db_d = db_q;
    m_d = m_q; st_d = st_q;
    r_d = r_q; qt_d = qt_q; cnt_d = cnt_q;

    a_nan  = (a_i[30:23] == 8'hFF) && (a_i[22:0] != 23'd0);
    b_nan  = (b_i[30:23] == 8'hFF) && (b_i[22:0] != 23'd0);
    a_inf  = (a_i[30:23] == 8'hFF) && (a_i[22:0] == 23'd0);
    b_inf  = (b_i[30:23] == 8'hFF) && (b_i[22:0] == 23'd0);
    a_zero = (a_i[30:0] == 31'd0);
    b_zero = (b_i[30:0] == 31'd0);
    bs     = b_i[31] ^ (op_i == FP_SUB);
    sx     = a_i[31] ^ b_i[31];

    a_big  = (ea_q >= eb_q);
    diff   = a_big ? (ea_q - eb_q) : (eb_q - ea_q);
    ebig   = a_big ? ea_q : eb_q;
    mbig   = {1'b0, (a_big ? da_q : db_q), 25'd0};
    msml   = {1'b0, (a_big ? db_q : da_q), 25'd0};
    mshift = '0;
    mmask  = '0;
    sticky = 1'b0;
    msum   = '0;
    prod   = da_q * db_q;
    rsub   = '0;
    ge     = 1'b0;
    qn     = '0;
    mant   = '0;
    mant_r = '0;
    sum25  = '0;
    g      = 1'b0;
    stk    = 1'b0;
    inc    = 1'b0;
    e_r    = '0;

    case (state_q)
      F_IDLE: begin
        if (start_i) begin
          sa_d = a_i[31];
          sb_d = bs;
          ea_d = (a_i[30:23] == 8'd0) ? 12'sd1 : $signed({4'd0, a_i[30:23]});
          eb_d = (b_i[30:23] == 8'd0) ? 12'sd1 : $signed({4'd0, b_i[30:23]});
          da_d = {a_i[30:23] != 8'd0, a_i[22:0]};
          db_d = {b_i[30:23] != 8'd0, b_i[22:0]};
          s_d  = sx;
          st_d = 1'b0;
          case (op_i)
            FP_ADD, FP_SUB: begin
              if (a_nan || b_nan || (a_inf && b_inf && (a_i[31] != bs))) begin
                res_d = CanonNan; done_d = 1'b1;
              end else if (a_inf) begin
                res_d = {a_i[31], 8'hFF, 23'd0}; done_d = 1'b1;
              end else if (b_inf) begin
                res_d = {bs, 8'hFF, 23'd0}; done_d = 1'b1;
              end else if (a_zero && b_zero) begin
                res_d = {a_i[31] & bs, 31'd0}; done_d = 1'b1;
              end else begin
                state_d = F_ADD;
              end
            end
            FP_MUL: begin
              if (a_nan || b_nan || (a_inf && b_zero) || (a_zero && b_inf)) begin
                res_d = CanonNan; done_d = 1'b1;
              end else if (a_inf || b_inf) begin
                res_d = {sx, 8'hFF, 23'd0}; done_d = 1'b1;
              end else if (a_zero || b_zero) begin
                res_d = {sx, 31'd0}; done_d = 1'b1;
              end else begin
                state_d = F_MUL;
              end
            end
            default: begin
              if (a_nan || b_nan || (a_inf && b_inf) || (a_zero && b_zero)) begin
                res_d = CanonNan; done_d = 1'b1;
              end else if (a_inf || b_zero) begin
                res_d = {sx, 8'hFF, 23'd0}; done_d = 1'b1;
              end else if (a_zero || b_inf) begin
                res_d = {sx, 31'd0}; done_d = 1'b1;
              end else begin
                state_d = F_PRE;
              end
            end
          endcase
        end
      end
      F_ADD: begin
        if (diff >= 12'sd50) begin
          mshift = '0;
          sticky = (msml != 50'd0);
        end else begin
          mshift = msml >> diff[5:0];
          mmask  = (50'd1 << diff[5:0]) - 50'd1;
          sticky = ((msml & mmask) != 50'd0);
        end
        mshift[0] = mshift[0] | sticky;
        if ((a_big ? sa_q : sb_q) == (a_big ? sb_q : sa_q)) begin
          msum = mbig + mshift;
          s_d  = a_big ? sa_q : sb_q;
        end else if (mbig >= mshift) begin
          msum = mbig - mshift;
          s_d  = a_big ? sa_q : sb_q;
        end else begin
          msum = mshift - mbig;
          s_d  = a_big ? sb_q : sa_q;
        end
        m_d     = msum;
        e_d     = ebig + 12'sd1;
        // exact cancellation gives plus zero
        if (msum == 50'd0) begin
          s_d = 1'b0;
          e_d = 12'sd1;
        end
        state_d = F_NORM;
      end
      F_MUL: begin
        m_d     = {prod, 2'b00};
        e_d     = ea_q + eb_q - 12'sd126;
        state_d = F_NORM;
      end
      F_PRE: begin
        if (!da_q[23]) begin
          if (da_q[23:16] == 8'd0) begin
            da_d = da_q << 8; ea_d = ea_q - 12'sd8;
          end else begin
            da_d = da_q << 1; ea_d = ea_q - 12'sd1;
          end
        end
        if (!db_q[23]) begin
          if (db_q[23:16] == 8'd0) begin
            db_d = db_q << 8; eb_d = eb_q - 12'sd8;
          end else begin
            db_d = db_q << 1; eb_d = eb_q - 12'sd1;
          end
        end
        if (da_q[23] && db_q[23]) begin
          r_d     = {2'b00, da_q};
          qt_d    = '0;
          cnt_d   = 5'd26;
          state_d = F_DIV;
        end
      end
      F_DIV: begin
        ge   = (r_q >= {2'b00, db_q});
        rsub = ge ? (r_q - {2'b00, db_q}) : r_q;
        qn   = {qt_q[25:0], ge};
        qt_d = qn;
        r_d  = rsub << 1;
        cnt_d = cnt_q - 5'd1;
        if (cnt_q == 5'd0) begin
          m_d     = {qn, 23'd0};
          st_d    = (rsub != 26'd0);
          e_d     = ea_q - eb_q + 12'sd127;
          state_d = F_NORM;
        end
      end
      F_NORM: begin
        if (e_q < 12'sd1) begin
          if (e_q < -12'sd60) begin
            m_d = '0; st_d = st_q | (m_q != 50'd0); e_d = 12'sd1;
          end else if (e_q <= -12'sd7) begin
            m_d = m_q >> 8; st_d = st_q | (m_q[7:0] != 8'd0); e_d = e_q + 12'sd8;
          end else begin
            m_d = m_q >> 1; st_d = st_q | m_q[0]; e_d = e_q + 12'sd1;
          end
        end else if (!m_q[49] && (e_q > 12'sd1) && (m_q != 50'd0)) begin
          if ((m_q[49:42] == 8'd0) && (e_q > 12'sd8)) begin
            m_d = m_q << 8; e_d = e_q - 12'sd8;
          end else begin
            m_d = m_q << 1; e_d = e_q - 12'sd1;
          end
        end else begin
          state_d = F_ROUND;
        end
      end
      F_ROUND: begin
        mant  = m_q[49:26];
        g     = m_q[25];
        stk   = st_q | (m_q[24:0] != 25'd0);
        inc   = g & (stk | mant[0]);
        sum25 = {1'b0, mant} + {24'd0, inc};
        if (sum25[24]) begin
          mant_r = sum25[24:1];
          e_r    = e_q + 12'sd1;
        end else begin
          mant_r = sum25[23:0];
          e_r    = e_q;
        end
        if (e_r >= 12'sd255) begin
          res_d = {s_q, 8'hFF, 23'd0};
        end else begin
          res_d = {s_q, (mant_r[23] ? e_r[7:0] : 8'h00), mant_r[22:0]};
        end
        done_d  = 1'b1;
        state_d = F_IDLE;
      end
      default: state_d = F_IDLE;
    endcase
  end

endmodule

### hdl/fsbe_dp.sv
// ----------------------------------------------------------------------------
// fsbe_dp
// Datapath: operand stack and constant pool memories, stack count, cached
// top of stack, float unit and the output word register.
// ----------------------------------------------------------------------------
module fsbe_dp import fsbe_pkg::*; #(
  parameter int STACK_DEPTH = StackDepth,
  parameter int POOL_DEPTH  = PoolDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ctrl_cmd_t   cmd_i,
  output dp_stat_t    stat_o,
  input  logic [2:0]  mode_i,
  input  logic [7:0]  index_i,
  input  logic [31:0] pool_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] top_value_o,
  output logic [8:0]  depth_o,
  output logic        has_value_o,
  output logic [1:0]  status_o
);

  localparam int SAW = $clog2(STACK_DEPTH);
  localparam int CW  = $clog2(STACK_DEPTH + 1);
  localparam int PAW = $clog2(POOL_DEPTH);

  logic [31:0] stack_mem [STACK_DEPTH];
  logic [31:0] pool_mem  [POOL_DEPTH];

  mode_e       mode_q;
  logic [7:0]  index_q;
  logic [31:0] pool_value_q;
  logic [CW-1:0] count_q, count_d, cm1, cm2;
  logic [31:0] top_q, top_d;
  logic [31:0] pool_rd_q, stk_rd_q;
  status_e     status_q;
  logic        out_valid_q;
  logic [31:0] out_top_q;
  logic [8:0]  out_depth_q;
  logic        out_has_q;
  status_e     out_status_q;

  logic          pool_hit;
  logic [PAW-1:0] pool_addr;
  logic [31:0]   push_data;
  logic          stk_we;
  logic [SAW-1:0] stk_waddr;
  logic [31:0]   stk_wdata;
  logic          fp_done;
  logic [31:0]   fp_res;

  assign cm1       = count_q - CW'(1);
  assign cm2       = count_q - CW'(2);
  assign pool_hit  = ({24'd0, index_q} < 32'(POOL_DEPTH));
  assign pool_addr = PAW'({24'd0, index_q});
  assign push_data = pool_hit ? pool_rd_q : 32'd0;

  assign stat_o.mode     = mode_q;
  assign stat_o.empty    = (count_q == '0);
  assign stat_o.lt2      = (count_q < CW'(2));
  assign stat_o.full     = (count_q >= CW'(STACK_DEPTH));
  assign stat_o.fp_done  = fp_done;
  assign stat_o.out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    stk_we    = cmd_i.push || cmd_i.neg || cmd_i.fp_wb;
    stk_waddr = cm2[SAW-1:0];
    stk_wdata = fp_res;
    if (cmd_i.push) begin
      stk_waddr = count_q[SAW-1:0];
      stk_wdata = push_data;
    end else if (cmd_i.neg) begin
      stk_waddr = cm1[SAW-1:0];
      stk_wdata = top_q ^ SignBit;
    end
  end

  always_comb begin
    top_d   = top_q;
    count_d = count_q;
    if (cmd_i.push) begin
      top_d   = push_data;
      count_d = count_q + CW'(1);
    end else if (cmd_i.neg) begin
      top_d = top_q ^ SignBit;
    end else if (cmd_i.fp_wb) begin
      top_d   = fp_res;
      count_d = cm1;
    end else if (cmd_i.out_load && (mode_q == MODE_RET)) begin
      count_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stack_mem[stk_waddr] <= stk_wdata;
    end
    if (cmd_i.stk_rd) begin
      stk_rd_q <= stack_mem[cm2[SAW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pool_wr && pool_hit) begin
      pool_mem[pool_addr] <= pool_value_q;
    end
    if (cmd_i.pool_rd) begin
      pool_rd_q <= pool_mem[pool_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      mode_q       <= mode_e'(mode_i);
      index_q      <= index_i;
      pool_value_q <= pool_value_i;
    end
    if (cmd_i.status_we) begin
      status_q <= cmd_i.status;
    end
    top_q <= top_d;
    if (cmd_i.out_load) begin
      out_top_q    <= (count_q != '0) ? top_q : 32'd0;
      out_depth_q  <= (mode_q == MODE_RET) ? 9'd0 : 9'(count_q);
      out_has_q    <= (count_q != '0);
      out_status_q <= status_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  fsbe_fpu u_fpu (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.fp_start),
    .op_i    (fp_op_e'(mode_q[1:0])),
    .a_i     (stk_rd_q),
    .b_i     (top_q),
    .done_o  (fp_done),
    .res_o   (fp_res)
  );

  assign out_valid_o = out_valid_q;
  assign top_value_o = out_top_q;
  assign depth_o     = out_depth_q;
  assign has_value_o = out_has_q;
  assign status_o    = out_status_q;

endmodule

### hdl/fsbe_ctrl.sv
// ----------------------------------------------------------------------------
// fsbe_ctrl
// Controller: sequences each instruction word through the datapath.
// ----------------------------------------------------------------------------
module fsbe_ctrl import fsbe_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  dp_stat_t  stat_i,
  output ctrl_cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_EXEC;
      S_EXEC: begin
        case (stat_i.mode)
          MODE_PUSH: state_d = stat_i.full ? S_DONE : S_PUSH;
          MODE_ADD, MODE_MUL, MODE_DIV, MODE_SUB:
            state_d = stat_i.lt2 ? S_DONE : S_FP_START;
          default: state_d = S_DONE;
        endcase
      end
      S_PUSH:     state_d = S_DONE;
      S_FP_START: state_d = S_FP_WAIT;
      S_FP_WAIT:  if (stat_i.fp_done) state_d = S_DONE;
      S_DONE:     if (stat_i.out_free) state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o        = '0;
    cmd_o.status = STAT_OK;
    in_stall_o   = (state_q != S_IDLE);
    case (state_q)
      S_IDLE: cmd_o.latch = in_valid_i;
      S_EXEC: begin
        cmd_o.status_we = 1'b1;
        case (stat_i.mode)
          MODE_POOL_WR: cmd_o.pool_wr = 1'b1;
          MODE_RET:     cmd_o.status = STAT_RET;
          MODE_PUSH: begin
            if (stat_i.full) cmd_o.status = STAT_OVER;
            else cmd_o.pool_rd = 1'b1;
          end
          MODE_NEG: begin
            if (stat_i.empty) cmd_o.status = STAT_UNDER;
            else cmd_o.neg = 1'b1;
          end
          default: begin
            if (stat_i.lt2) cmd_o.status = STAT_UNDER;
            else cmd_o.stk_rd = 1'b1;
          end
        endcase
      end
      S_PUSH:     cmd_o.push = 1'b1;
      S_FP_START: cmd_o.fp_start = 1'b1;
      S_FP_WAIT:  cmd_o.fp_wb = stat_i.fp_done;
      S_DONE:     cmd_o.out_load = stat_i.out_free;
      default:    cmd_o = '0;
    endcase
  end

endmodule

### hdl/float_stack_bytecode_executor.sv
// ----------------------------------------------------------------------------
// float_stack_bytecode_executor
// Stack-machine executor for IEEE single-precision values.
// ----------------------------------------------------------------------------
// One instruction word is taken at a time and gives one result word. Add,
// subtract and multiply pass through the one-bit-or-one-byte normalize loop
// of the float unit; divide runs the 27-step restoring divider after operand
// pre-normalization. An operation whose result follows from a zero, infinite
// or NaN operand skips these steps. A finished result word waits in the
// output register while the next word is accepted.
// ----------------------------------------------------------------------------
module float_stack_bytecode_executor import fsbe_pkg::*; #(
  parameter int STACK_DEPTH = StackDepth,
  parameter int POOL_DEPTH  = PoolDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  mode_i,
  input  logic [7:0]  index_i,
  input  logic [31:0] pool_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] top_value_o,
  output logic [8:0]  depth_o,
  output logic        has_value_o,
  output logic [1:0]  status_o
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  fsbe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  fsbe_dp #(
    .STACK_DEPTH (STACK_DEPTH),
    .POOL_DEPTH  (POOL_DEPTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .mode_i       (mode_i),
    .index_i      (index_i),
    .pool_value_i (pool_value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .top_value_o  (top_value_o),
    .depth_o      (depth_o),
    .has_value_o  (has_value_o),
    .status_o     (status_o)
  );

endmodule

### bench/float_stack_bytecode_executor_chk.sv
// ----------------------------------------------------------------------------
// float_stack_bytecode_executor_chk
// Watches both word channels of the executor, keeps its own copy of the
// operand stack and constant pool, predicts every result word with float
// arithmetic rounded to nearest even and compares it field by field.
// ----------------------------------------------------------------------------
module float_stack_bytecode_executor_chk import fsbe_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [2:0]  mode_i,
  input  logic [7:0]  index_i,
  input  logic [31:0] pool_value_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [31:0] top_value_i,
  input  logic [8:0]  depth_i,
  input  logic        has_value_i,
  input  logic [1:0]  status_i,
  output int          pending_o,
  output int          fail_count_o
);

  typedef struct packed {
    logic [31:0] top_value;
    logic [8:0]  depth;
    logic        has_value;
    status_e     status;
  } result_t;

  logic [31:0] stack_mem [StackDepth];
  logic [31:0] pool_mem [PoolDepth];
  int          stack_cnt;
  result_t     result_q[$];

  assign pending_o = result_q.size();

  function automatic bit is_nan(logic [31:0] b);
    return b[30:23] == 8'hFF && b[22:0] != 0;
  endfunction

  function automatic bit is_inf(logic [31:0] b);
    return b[30:23] == 8'hFF && b[22:0] == 0;
  endfunction

  function automatic bit is_zero(logic [31:0] b);
    return b[30:0] == 0;
  endfunction

  // single to double bits, exact
  function automatic logic [63:0] widen(logic [31:0] b);
    logic [23:0] f;
    int          e;
    f = {1'b1, b[22:0]};
    e = int'(b[30:23]);
    if (is_zero(b)) return {b[31], 63'b0};
    if (e == 0) begin
      e = 1;
      f = {1'b0, b[22:0]};
      while (!f[23]) begin
        f = f << 1;
        e = e - 1;
      end
    end
    return {b[31], 11'(e - 127 + 1023), f[22:0], 29'b0};
  endfunction

  // double to single bits, round to nearest even
  function automatic logic [31:0] narrow(logic [63:0] d);
    int           e;
    int           k;
    logic [52:0]  sig;
    logic [127:0] ext;
    logic [31:0]  base;
    logic         up;
    if (d[62:52] == 0) return {d[63], 31'b0};
    e = int'(d[62:52]) - 1023;
    sig = {1'b1, d[51:0]};
    if (e > 127) return {d[63], 8'hFF, 23'b0};
    if (e >= -126) begin
      base = {1'b0, 8'(e + 127), sig[51:29]};
      up = sig[28] && ((|sig[27:0]) || sig[29]);
    end else begin
      k = -97 - e;
      if (k > 120) k = 120;
      ext = {sig, 75'b0} >> k;
      base = 32'(ext[127:75]);
      up = ext[74] && ((|ext[73:0]) || ext[75]);
    end
    base = base + 32'(up);
    base[31] = d[63];
    return base;
  endfunction

  function automatic logic [31:0] float_op(mode_e mode, logic [31:0] a, logic [31:0] b);
    logic sgn;
    real  r;
    sgn = a[31] ^ b[31];
    if (is_nan(a) || is_nan(b)) return CanonNan;
    case (mode)
      MODE_ADD, MODE_SUB: begin
        if (mode == MODE_SUB) b = b ^ SignBit;
        if (is_inf(a) && is_inf(b)) return (a[31] == b[31]) ? a : CanonNan;
        if (is_inf(a)) return a;
        if (is_inf(b)) return b;
        r = $bitstoreal(widen(a)) + $bitstoreal(widen(b));
      end
      MODE_MUL: begin
        if (is_inf(a) || is_inf(b)) begin
          if (is_zero(a) || is_zero(b)) return CanonNan;
          return {sgn, 8'hFF, 23'b0};
        end
        r = $bitstoreal(widen(a)) * $bitstoreal(widen(b));
      end
      default: begin
        if (is_inf(a)) return is_inf(b) ? CanonNan : {sgn, 8'hFF, 23'b0};
        if (is_inf(b)) return {sgn, 31'b0};
        if (is_zero(b)) return is_zero(a) ? CanonNan : {sgn, 8'hFF, 23'b0};
        r = $bitstoreal(widen(a)) / $bitstoreal(widen(b));
      end
    endcase
    return narrow($realtobits(r));
  endfunction

  function automatic result_t execute(mode_e mode, logic [7:0] idx, logic [31:0] val);
    result_t res;
    res = '0;
    res.status = STAT_OK;
    case (mode)
      MODE_POOL_WR: pool_mem[idx] = val;
      MODE_RET: begin
        if (stack_cnt > 0) begin
          res.top_value = stack_mem[stack_cnt - 1];
          res.has_value = 1'b1;
        end
        stack_cnt = 0;
        res.status = STAT_RET;
        return res;
      end
      MODE_PUSH: begin
        if (stack_cnt >= StackDepth) res.status = STAT_OVER;
        else begin
          stack_mem[stack_cnt] = pool_mem[idx];
          stack_cnt++;
        end
      end
      MODE_NEG: begin
        if (stack_cnt == 0) res.status = STAT_UNDER;
        else stack_mem[stack_cnt - 1] = stack_mem[stack_cnt - 1] ^ SignBit;
      end
      default: begin
        if (stack_cnt < 2) res.status = STAT_UNDER;
        else begin
          stack_mem[stack_cnt - 2] =
            float_op(mode, stack_mem[stack_cnt - 2], stack_mem[stack_cnt - 1]);
          stack_cnt--;
        end
      end
    endcase
    if (stack_cnt > 0) begin
      res.top_value = stack_mem[stack_cnt - 1];
      res.has_value = 1'b1;
    end
    res.depth = 9'(stack_cnt);
    return res;
  endfunction

  task automatic report(string field, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, exp_v, act_v);
      fail_count_o++;
    end
  endtask

  initial begin
    fail_count_o = 0;
    stack_cnt = 0;
  end

  always @(posedge clk_i) begin
    result_t exp_r;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_i)
        result_q.insert(result_q.size(), execute(mode_e'(mode_i), index_i, pool_value_i));
      if (out_valid_i && !out_stall_i) begin
        if (result_q.size() == 0) begin
          $display("%0t: unexpected result word, expected none, actual %h", $time,
                   top_value_i);
          fail_count_o++;
        end else begin
          exp_r = result_q.pop_front();
          report("top_value", exp_r.top_value, top_value_i);
          report("depth", 32'(exp_r.depth), 32'(depth_i));
          report("has_value", 32'(exp_r.has_value), 32'(has_value_i));
          report("status", 32'(exp_r.status), 32'(status_i));
        end
      end
    end
  end

endmodule

### bench/float_stack_bytecode_executor_tb.sv
// ----------------------------------------------------------------------------
// float_stack_bytecode_executor_tb
// Drives instruction words into the executor: directed pool writes and
// special float cases, a full-stack overflow run, then random programs under
// three idling regimes. The checker predicts and compares every result word.
// ----------------------------------------------------------------------------
module float_stack_bytecode_executor_tb;
  import fsbe_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [2:0]  mode_i = '0;
  logic [7:0]  index_i = '0;
  logic [31:0] pool_value_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] top_value_o;
  logic [8:0]  depth_o;
  logic        has_value_o;
  logic [1:0]  status_o;

  int pending;
  int fail_count;
  int cycles = 0;
  int send_idle = 0;
  int recv_idle = 0;
  bit pool_set [PoolDepth];

  always #5 clk_i = ~clk_i;

  float_stack_bytecode_executor u_dut (.*);

  float_stack_bytecode_executor_chk u_chk (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .mode_i, .index_i,
    .pool_value_i, .out_valid_i(out_valid_o), .out_stall_i, .top_value_i(top_value_o),
    .depth_i(depth_o), .has_value_i(has_value_o), .status_i(status_o),
    .pending_o(pending), .fail_count_o(fail_count)
  );

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > 1000000) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    out_stall_i = ($urandom_range(99) < recv_idle);
  end

  task automatic send_word(mode_e mode, logic [7:0] idx, logic [31:0] val);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    mode_i = mode;
    index_i = idx;
    pool_value_i = val;
    if (mode == MODE_POOL_WR) pool_set[idx] = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  function automatic logic [31:0] float_bits();
    case ($urandom_range(11))
      0: return 32'h0000_0000;
      1: return SignBit;
      2: return 32'h7F80_0000;
      3: return 32'hFF80_0000;
      4: return {1'($urandom_range(1)), 8'hFF, 23'($urandom_range(1, 32'h7F_FFFF))};
      5: return 32'h0000_0001;
      6: return {1'($urandom_range(1)), 8'h00, 23'($urandom)};
      7: return 32'h7F7F_FFFF;
      8: return 32'h3F80_0000;
      9: return {1'($urandom_range(1)), 8'($urandom_range(250, 254)), 23'($urandom)};
      10: return {1'($urandom_range(1)), 8'($urandom_range(120, 134)), 23'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [7:0] written_index();
    logic [7:0] idx;
    idx = 8'($urandom_range(255));
    while (!pool_set[idx]) idx = 8'($urandom_range(255));
    return idx;
  endfunction

  task automatic random_program(int count);
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < 10) send_word(MODE_POOL_WR, 8'($urandom_range(255)), float_bits());
      else if (r < 50) send_word(MODE_PUSH, written_index(), $urandom);
      else if (r < 56) send_word(MODE_NEG, 8'($urandom), $urandom);
      else if (r < 94)
        send_word(mode_e'(3'(4 + $urandom_range(3))), 8'($urandom), $urandom);
      else send_word(MODE_RET, 8'($urandom), $urandom);
    end
  endtask

  task automatic wait_drained();
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: special pool values and corner operations
    send_word(MODE_POOL_WR, 8'd0, 32'h3F80_0000);
    send_word(MODE_POOL_WR, 8'd255, 32'hBF80_0000);
    send_word(MODE_POOL_WR, 8'd1, 32'h0000_0000);
    send_word(MODE_POOL_WR, 8'd2, SignBit);
    send_word(MODE_POOL_WR, 8'd3, 32'h7F80_0000);
    send_word(MODE_POOL_WR, 8'd4, 32'hFFFF_FFFF);
    send_word(MODE_POOL_WR, 8'd5, 32'h0000_0001);
    send_word(MODE_POOL_WR, 8'd6, 32'h7F7F_FFFF);
    send_word(MODE_POOL_WR, 8'd7, 32'h0080_0000);
    send_word(MODE_NEG, 8'd0, 32'h0);
    send_word(MODE_ADD, 8'd0, 32'h0);
    send_word(MODE_PUSH, 8'd0, 32'h0);
    send_word(MODE_SUB, 8'd0, 32'h0);
    send_word(MODE_PUSH, 8'd6, 32'h0);
    send_word(MODE_PUSH, 8'd6, 32'h0);
    send_word(MODE_MUL, 8'd0, 32'h0);
    send_word(MODE_PUSH, 8'd3, 32'h0);
    send_word(MODE_SUB, 8'd0, 32'h0);
    send_word(MODE_PUSH, 8'd1, 32'h0);
    send_word(MODE_DIV, 8'd0, 32'h0);
    send_word(MODE_NEG, 8'd0, 32'h0);
    send_word(MODE_PUSH, 8'd5, 32'h0);
    send_word(MODE_PUSH, 8'd7, 32'h0);
    send_word(MODE_MUL, 8'd0, 32'h0);
    send_word(MODE_PUSH, 8'd4, 32'h0);
    send_word(MODE_ADD, 8'd0, 32'h0);
    send_word(MODE_RET, 8'd0, 32'h0);
    send_word(MODE_RET, 8'd0, 32'h0);

    // full stack and overflow, started from an empty pipeline
    wait_drained();
    for (int i = 0; i <= StackDepth; i++) send_word(MODE_PUSH, written_index(), $urandom);
    send_word(MODE_NEG, 8'd0, 32'h0);
    send_word(MODE_RET, 8'd255, 32'hFFFF_FFFF);

    send_idle = 30;
    recv_idle = 74;
    random_program(38);
    wait_drained();
    send_idle = 74;
    recv_idle = 30;
    random_program(38);
    send_idle = 0;
    recv_idle = 0;
    random_program(38);

    wait_drained();
    repeat (100) @(posedge clk_i);
    if (fail_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
